// File: hdl/tlg_pkg.sv
// Shared types and constants for the tremolo LFO gain core.
package tlg_pkg;

    // LFO waveform codes as held in the shape register
    typedef enum logic [1:0] {
        SHAPE_TRIANGLE = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_SLOPED   = 2'd2,
        SHAPE_SINE     = 2'd3
    } wave_shape_t;

    // Sequencer states of the sample path
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_GAIN  = 2'd1,
        ST_SCALE = 2'd2
    } tlg_state_t;

    // Configuration register indexes
    localparam logic [1:0] REG_LFO_STEP   = 2'd0;
    localparam logic [1:0] REG_MOD_DEPTH  = 2'd1;
    localparam logic [1:0] REG_WAVE_SHAPE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] LFO_STEP_RST  = 16'd3;
    localparam logic [14:0] MOD_DEPTH_RST = 15'd32767;

    // Largest Q1.15 value; 1.0 saturates to this
    localparam logic [14:0] ONE_SAT = 15'h7FFF;

    // Phase break points: quarter, three quarters, 0.48, half and 0.98 of a cycle
    localparam logic [15:0] PH_QUARTER  = 16'd16384;
    localparam logic [15:0] PH_3QUARTER = 16'd49152;
    localparam logic [15:0] PH_FALL     = 16'd31458;
    localparam logic [15:0] PH_HALF     = 16'd32768;
    localparam logic [15:0] PH_RISE     = 16'd64226;

    // Sloped edge offsets (slope 50 per cycle is 25 per phase unit in Q1.15)
    localparam logic [20:0] FALL_OFFSET = 21'd819200;
    localparam logic [20:0] RISE_OFFSET = 21'd1605632;

endpackage

// File: hdl/tlg_lfo.sv
// LFO value for the triangle, square and sloped square shapes.
module tlg_lfo (
    input  logic [15:0]         phase,
    input  tlg_pkg::wave_shape_t shape,
    output logic [14:0]         lfo_value
);
    import tlg_pkg::*;

    logic [20:0] phase_x25;
    logic [16:0] tri_raw;
    logic [20:0] slope_raw;

    // Scale phase by 25 with shifts and adds
    assign phase_x25 = {1'b0, phase, 4'd0} + {2'd0, phase, 3'd0} + {5'd0, phase};

    // Triangle: rise from one half, fall to zero, rise again
    always_comb
    begin
        if (phase < PH_QUARTER)
        begin
            tri_raw = 17'(PH_QUARTER) + 17'(phase);
        end
        else if (phase < PH_3QUARTER)
        begin
            tri_raw = 17'(PH_3QUARTER) - 17'(phase);
        end
        else
        begin
            tri_raw = 17'(phase) - 17'(PH_3QUARTER);
        end
    end

    // Sloped edges, only used inside their own phase windows
    assign slope_raw = (phase < PH_HALF) ? (FALL_OFFSET - phase_x25)
                                         : (phase_x25 - RISE_OFFSET);

    // Select the shape and saturate 1.0
    always_comb
    begin
        case (shape)
            SHAPE_TRIANGLE:
            begin
                lfo_value = (tri_raw > 17'(ONE_SAT)) ? ONE_SAT : tri_raw[14:0];
            end
            SHAPE_SQUARE:
            begin
                lfo_value = phase[15] ? 15'd0 : ONE_SAT;
            end
            SHAPE_SLOPED:
            begin
                if (phase < PH_FALL)
                begin
                    lfo_value = ONE_SAT;
                end
                else if (phase < PH_HALF)
                begin
                    lfo_value = slope_raw[14:0];
                end
                else if (phase < PH_RISE)
                begin
                    lfo_value = 15'd0;
                end
                else
                begin
                    lfo_value = slope_raw[14:0];
                end
            end
            default:
            begin
                lfo_value = 15'd0;
            end
        endcase
    end

endmodule

// File: hdl/tlg_sine_rom.sv
// Synchronous raised-sine ROM addressed by the LFO phase scaled to the table size.
module tlg_sine_rom #(
    parameter int ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rd_en,
    input  logic [15:0] phase,
    output logic [14:0] rd_data
);
    import tlg_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = 16 + IW + 1;

    // Raised sine by integer Taylor series, rounded to nearest
    function automatic logic [14:0] raised_sine(input int unsigned idx);
        logic [63:0]        f;
        logic [63:0]        r;
        logic [63:0]        u;
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic [1:0]         quad;
        logic [31:0]        v;
        int                 k;
        f    = ({32'd0, idx} << 32) / 64'(ENTRIES);
        quad = f[31:30];
        r    = f & 64'h3FFF_FFFF;
        u    = quad[0] ? (64'h4000_0000 - r) : r;
        a    = (u * 64'd6746518852) >> 32;
        a2   = (a * a) >> 30;
        term = a;
        sum  = signed'(a);
        for (k = 1; k <= 7; k++)
        begin
            term = (term * a2) >> 30;
            case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                default: term = term / 210;
            endcase
            if (k % 2 == 1)
            begin
                sum = sum - signed'(term);
            end
            else
            begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        mag = ((unsigned'(sum) << 14) + (64'd1 << 29)) >> 30;
        if (mag > 64'd16384)
        begin
            mag = 64'd16384;
        end
        if (quad[1])
        begin
            v = 32'd16384 - mag[31:0];
        end
        else
        begin
            v = 32'd16384 + mag[31:0];
        end
        return (v > 32'(ONE_SAT)) ? ONE_SAT : v[14:0];
    endfunction

    logic [14:0]    rom_lut [ENTRIES];
    logic [PW-1:0]  addr_prod;
    logic [IW-1:0]  rd_addr;
    logic [14:0]    rd_data_reg;

    // Build the table contents at elaboration
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_lut
        assign rom_lut[g] = raised_sine(g);
    end

    // Map phase onto the table: index = phase * ENTRIES / 65536
    assign addr_prod = PW'(phase) * PW'(ENTRIES);
    assign rd_addr   = addr_prod[16 +: IW];

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom_lut[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/tremolo_lfo_gain_core.sv
// Top level of the tremolo LFO gain core: configuration, sequencer and shared multiplier.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------
//  audio    | audio_valid / audio_stall  | sample_in  (s16, Q1.15)
//  result   | result_valid / result_stall| sample_out (s16, Q1.15)
//  config   | cfg_we                     | cfg_index, cfg_data
//
// A sample passes three steps: accept (LFO value and sine ROM read), gain, scale.
// One 17x17 multiplier is shared by the gain and scale steps.
// The result register parts the two sides; a new sample is taken while it waits.
// A stalled result holds the sequencer in the scale step until the register frees.
// Reset loads the register defaults and clears the phase; no clearing pass is needed.
module tremolo_lfo_gain_core #(
    parameter int SINE_ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               audio_valid,
    output logic               audio_stall,
    input  logic signed [15:0] sample_in,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] sample_out
);
    import tlg_pkg::*;

    // Configuration and control state
    logic [15:0]        step_reg;
    logic [15:0]        step_next;
    logic [14:0]        depth_reg;
    logic [14:0]        depth_next;
    wave_shape_t        shape_reg;
    wave_shape_t        shape_next;
    logic [15:0]        phase_reg;
    logic [15:0]        phase_next;
    tlg_state_t         state_reg;
    tlg_state_t         state_next;
    logic               result_valid_reg;
    logic               result_valid_next;

    // Payload registers
    logic signed [15:0] sample_reg;
    logic [14:0]        lfo_reg;
    logic [14:0]        gain_reg;
    logic [14:0]        gain_next;
    logic signed [15:0] out_reg;

    logic               accept;
    logic               load_gain;
    logic               load_out;
    logic [14:0]        lfo_value;
    logic [14:0]        sine_value;
    logic [14:0]        lfo_sel;
    logic [14:0]        depth_prod;
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;

    tlg_lfo u_lfo (
        .phase     (phase_reg),
        .shape     (shape_reg),
        .lfo_value (lfo_value)
    );

    tlg_sine_rom #(
        .ENTRIES (SINE_ENTRIES)
    ) u_sine_rom (
        .clk     (clk),
        .rd_en   (accept),
        .phase   (phase_reg),
        .rd_data (sine_value)
    );

    assign accept = audio_valid && !audio_stall;

    // Sequencer: accept, form gain, scale and hand to the result register
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        audio_stall       = 1'b1;
        load_gain         = 1'b0;
        load_out          = 1'b0;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                audio_stall = 1'b0;
                if (audio_valid)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                load_gain  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_out          = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes and phase advance
    always_comb
    begin
        step_next  = step_reg;
        depth_next = depth_reg;
        shape_next = shape_reg;
        phase_next = phase_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LFO_STEP:   step_next  = cfg_data;
                REG_MOD_DEPTH:  depth_next = cfg_data[14:0];
                REG_WAVE_SHAPE: shape_next = wave_shape_t'(cfg_data[1:0]);
                default:        step_next  = step_reg;
            endcase
        end
        if (accept)
        begin
            phase_next = phase_reg + step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= LFO_STEP_RST;
            depth_reg        <= MOD_DEPTH_RST;
            shape_reg        <= SHAPE_SINE;
            phase_reg        <= 16'd0;
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            depth_reg        <= depth_next;
            shape_reg        <= shape_next;
            phase_reg        <= phase_next;
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Pick the LFO value; the sine comes from the ROM read issued at accept
    assign lfo_sel = (shape_reg == SHAPE_SINE) ? sine_value : lfo_reg;

    // Share the multiplier: depth times LFO, then sample times gain
    always_comb
    begin
        if (state_reg == ST_GAIN)
        begin
            mul_a = {2'b00, depth_reg};
            mul_b = {2'b00, lfo_sel};
        end
        else
        begin
            mul_a = {sample_reg[15], sample_reg};
            mul_b = {2'b00, gain_reg};
        end
    end

    assign mul_p = mul_a * mul_b;

    // Truncate the depth product and saturate a gain of one
    assign depth_prod = mul_p[29:15];
    assign gain_next  = (depth_prod == 15'd0) ? ONE_SAT
                                              : 15'(16'd32768 - {1'b0, depth_prod});

    // Capture payload at each step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_in;
            lfo_reg    <= lfo_value;
        end
        if (load_gain)
        begin
            gain_reg <= gain_next;
        end
        if (load_out)
        begin
            out_reg <= mul_p[30:15];
        end
    end

    assign result_valid = result_valid_reg;
    assign sample_out   = out_reg;

    // An accepted sample moves straight to the gain step
    a_accept_to_gain: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_GAIN))
        else $error("accepted sample did not enter gain step");

    // Phase advances by the step exactly once per accepted sample
    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (phase_reg == 16'($past(phase_reg) + $past(step_reg))))
        else $error("phase did not advance by step");

    // Phase holds while no sample is taken
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg))
        else $error("phase moved without a transfer");

    // A new result only appears from the scale step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_SCALE))
        else $error("result raised outside scale step");

    // Gain is never zero when scaling
    a_gain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |-> (gain_reg != 15'd0))
        else $error("zero gain in scale step");

endmodule

// File: dv/tremolo_lfo_gain_core_tb.sv
// Self-checking testbench for the tremolo LFO gain core: directed, back-pressure and random tests.
module tremolo_lfo_gain_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlg_pkg::*;

    typedef longint unsigned u64_t;

    localparam int         SINE_ENTRIES = 256;
    localparam int         CYCLE_LIMIT  = 800000;
    localparam int         HOLD_CYCLES  = 300;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               audio_valid;
    logic               audio_stall;
    logic signed [15:0] sample_in;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [15:0] sample_out;

    // Predictor copy of the registers, the phase and the sine table
    logic [15:0]        step_r;
    logic [14:0]        depth_r;
    wave_shape_t        shape_r;
    logic [15:0]        phase_r;
    int                 sine_tab [SINE_ENTRIES];

    logic signed [15:0] expected_out [$];
    logic signed [15:0] want_out;
    int                 fail_count  = 0;
    int                 cycle_count = 0;

    // Idle control shared by the sender and the receiver
    bit                 tx_no_idle = 1'b0;
    bit                 rx_no_idle = 1'b0;
    bit                 hold_req   = 1'b0;
    int                 hold_left  = 0;
    int                 stall_left = 0;

    tremolo_lfo_gain_core #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .audio_valid(audio_valid),
        .audio_stall(audio_stall),
        .sample_in(sample_in),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .sample_out(sample_out)
    );

    always #4 clk = ~clk;

    // Abort the run if it overruns
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** tremolo_lfo_gain_core: FAILED **");
            $finish;
        end
    end

    // Raised sine entry by integer Taylor series, rounded to the nearest step
    function automatic int raised_sine(input int i);
        u64_t   f, r, u, a, a2, term, mag;
        longint sum;
        int     quad, v;
        f    = (u64_t'(i) << 32) / u64_t'(SINE_ENTRIES);
        quad = int'((f >> 30) & 64'd3);
        r    = f & 64'h3FFF_FFFF;
        u    = (quad & 1) ? (64'd1073741824 - r) : r;
        a    = (u * 64'd6746518852) >> 32;
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * a2) >> 30;
            term = term / u64_t'((2 * k) * (2 * k + 1));
            if (k & 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        mag = ((u64_t'(sum) << 14) + 64'd536870912) >> 30;
        if (mag > 64'd16384)
            mag = 64'd16384;
        v = (quad >= 2) ? 16384 - int'(mag) : 16384 + int'(mag);
        return (v > 32767) ? 32767 : v;
    endfunction

    // LFO level in Q1.15 for a phase and shape, 1.0 held at full scale
    function automatic logic [14:0] lfo_level(input logic [15:0] ph, input wave_shape_t shp);
        int p, v;
        p = int'(ph);
        case (shp)
            SHAPE_TRIANGLE:
                if (p < 16384)
                    v = 16384 + p;
                else if (p < 49152)
                    v = 32768 - (p - 16384);
                else
                    v = p - 49152;
            SHAPE_SQUARE:
                v = (p < 32768) ? 32767 : 0;
            SHAPE_SLOPED:
                if (p < 31458)
                    v = 32767;
                else if (p < 32768)
                    v = 819200 - 25 * p;
                else if (p < 64226)
                    v = 0;
                else
                    v = 25 * p - 1605632;
            default:
                v = sine_tab[(p * SINE_ENTRIES) >> 16];
        endcase
        if (v > 32767)
            v = 32767;
        return v[14:0];
    endfunction

    // Scale a sample by 1 - depth * level, products truncated
    function automatic logic signed [15:0] tremolo_out(input logic signed [15:0] x,
                                                      input logic [14:0] depth,
                                                      input logic [14:0] lvl);
        int prod, gain, y;
        prod = (int'(depth) * int'(lvl)) >>> 15;
        gain = 32768 - prod;
        if (gain > 32767)
            gain = 32767;
        y = (int'(x) * gain) >>> 15;
        return y[15:0];
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] s;
        case ($urandom_range(0, 19))
            0:       s = 16'sh8000;
            1:       s = 16'sh7FFF;
            2:       s = 16'sh0000;
            3:       s = -16'sd1;
            4:       s = 16'sd1;
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    // Offer one sample, hold it until the transfer, then predict its result
    task automatic send_sample(input logic signed [15:0] s);
        int gap;
        gap = (tx_no_idle || $urandom_range(0, 99) < 50) ? 0 : pick_idle_len();
        if (gap > 0)
        begin
            audio_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        audio_valid <= 1'b1;
        sample_in   <= s;
        @(posedge clk);
        while (audio_stall)
            @(posedge clk);
        expected_out.push_back(tremolo_out(s, depth_r, lfo_level(phase_r, shape_r)));
        phase_r = phase_r + step_r;
    endtask

    // Drop valid and let every pending result drain before touching registers
    task automatic wait_idle();
        audio_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LFO_STEP:   step_r  = data;
            REG_MOD_DEPTH:  depth_r = data[14:0];
            REG_WAVE_SHAPE: shape_r = wave_shape_t'(data[1:0]);
            default: ;
        endcase
    endtask

    // Send one sample at the current phase with a step that lands on the target
    task automatic step_to(input logic [15:0] target);
        wait_idle();
        write_reg(REG_LFO_STEP, target - phase_r);
        send_sample(pick_sample());
    endtask

    task automatic set_shape(input wave_shape_t shp);
        wait_idle();
        write_reg(REG_WAVE_SHAPE, {14'd0, shp});
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
    endtask

    // Triangle corners, including the peak that saturates to full scale
    task automatic test_triangle();
        set_shape(SHAPE_TRIANGLE);
        step_to(16'd16383);
        step_to(16'd16384);
        step_to(16'd49151);
        step_to(16'd49152);
        step_to(16'd65535);
        send_sample(pick_sample());
    endtask

    task automatic test_square();
        set_shape(SHAPE_SQUARE);
        step_to(16'd32767);
        step_to(16'd32768);
        send_sample(pick_sample());
    endtask

    // Both sloped edges, each side of every break point
    task automatic test_sloped_edges();
        set_shape(SHAPE_SLOPED);
        step_to(16'd31457);
        step_to(16'd31458);
        step_to(16'd32767);
        step_to(16'd32768);
        step_to(16'd64225);
        step_to(16'd64226);
        step_to(16'd65535);
        send_sample(pick_sample());
    endtask

    // Last sine entry, then wrap the phase through zero
    task automatic test_sine_wrap();
        set_shape(SHAPE_SINE);
        step_to(16'd65535);
        step_to(16'd1);
        send_sample(pick_sample());
    endtask

    // Zero depth saturates the gain; unknown index and spare bits are ignored
    task automatic test_depth_and_masks();
        wait_idle();
        write_reg(REG_MOD_DEPTH, 16'd0);
        send_sample(16'sh8000);
        wait_idle();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_MOD_DEPTH, 16'hFFFF);
        write_reg(REG_WAVE_SHAPE, 16'hFFFE);
        send_sample(16'sh7FFF);
    endtask

    // Hold the result side off while samples keep coming, so the input stalls
    task automatic test_backpressure();
        hold_req   = 1'b1;
        tx_no_idle = 1'b1;
        repeat (24) send_sample(pick_sample());
        tx_no_idle = 1'b0;
    endtask

    task automatic test_random();
        logic [15:0] rnd;
        for (int blk = 0; blk < 10; blk++)
        begin
            wait_idle();
            case (blk)
                0:
                begin
                    write_reg(REG_LFO_STEP, 16'd0);
                    write_reg(REG_MOD_DEPTH, 16'd32767);
                    write_reg(REG_WAVE_SHAPE, {14'd0, SHAPE_TRIANGLE});
                end
                1:
                begin
                    write_reg(REG_LFO_STEP, 16'hFFFF);
                    write_reg(REG_MOD_DEPTH, 16'd0);
                    write_reg(REG_WAVE_SHAPE, {14'd0, SHAPE_SQUARE});
                end
                2:
                begin
                    write_reg(REG_LFO_STEP, 16'd191);
                    write_reg(REG_MOD_DEPTH, 16'd32767);
                    write_reg(REG_WAVE_SHAPE, {14'd0, SHAPE_SLOPED});
                end
                3:
                begin
                    write_reg(REG_LFO_STEP, 16'h8000);
                    write_reg(REG_MOD_DEPTH, 16'd16384);
                    write_reg(REG_WAVE_SHAPE, {14'd0, SHAPE_SINE});
                end
                default:
                begin
                    rnd = 16'($urandom);
                    write_reg(REG_LFO_STEP, rnd);
                    rnd = 16'($urandom);
                    write_reg(REG_MOD_DEPTH, rnd);
                    rnd = 16'($urandom);
                    write_reg(REG_WAVE_SHAPE, rnd);
                    rnd = 16'($urandom);
                    write_reg(REG_UNUSED, rnd);
                end
            endcase
            // Run one block flat out on both sides
            tx_no_idle = (blk == 5);
            rx_no_idle = (blk == 5);
            repeat (175) send_sample(pick_sample());
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // Check each result transfer, then choose the next stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_out.size() == 0)
            begin
                $error("sample_out: result with no sample pending, actual %0d", sample_out);
                fail_count++;
            end
            else
            begin
                want_out = expected_out.pop_front();
                if (sample_out !== want_out)
                begin
                    $error("sample_out: expected %0d, actual %0d", want_out, sample_out);
                    fail_count++;
                end
            end
        end
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (!rx_no_idle && $urandom_range(0, 99) < 30)
                stall_left = pick_idle_len();
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_LFO_STEP;
        cfg_data    = 16'd0;
        audio_valid = 1'b0;
        sample_in   = 16'sd0;
        for (int i = 0; i < SINE_ENTRIES; i++)
            sine_tab[i] = raised_sine(i);
        step_r  = 16'd3;
        depth_r = 15'd32767;
        shape_r = SHAPE_SINE;
        phase_r = 16'd0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_triangle();
        test_square();
        test_sloped_edges();
        test_sine_wrap();
        test_depth_and_masks();
        test_backpressure();
        test_random();

        // Drain the pipeline and allow for any late stray result
        audio_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** tremolo_lfo_gain_core: PASSED **");
        else
            $display("** tremolo_lfo_gain_core: FAILED **");
        $finish;
    end

endmodule
